FILE: design/ess_pkg.sv
// Shared constants and control/status types for the event sample statistics block.
`timescale 1ns / 1ps
package ess_pkg;
    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 32;
    localparam int LOG_FRAC_BITS = 16;
    localparam int COUNT_W       = 11;
    localparam int SUM_W         = 42;
    localparam int LOG_W         = 32;
    localparam int DIVD_W        = 50;
    localparam int MEAN_W        = 40;
    localparam int GEOM_W        = 39;
    localparam int SQRT_STEPS    = 32;

    typedef struct packed {
        logic       take;
        logic       norm_step;
        logic [2:0] norm_idx;
        logic       log_step;
        logic       log_add;
        logic       div_load_mean;
        logic       div_load_log;
        logic       div_step;
        logic       mean_save;
        logic       l_save;
        logic       sqrt_load;
        logic [3:0] frac_idx;
        logic       sqrt_step;
        logic [4:0] sqrt_idx;
        logic       sqrt_end;
        logic       geo_save;
        logic       out_load;
    } ess_cmd_t;

    typedef struct packed {
        logic log_needed;
        logic count_zero;
        logic zero_flag;
        logic out_free;
    } ess_status_t;
endpackage

FILE: design/ess_ctrl.sv
// Sequencer for sample accumulation, log, division and exp phases.
`timescale 1ns / 1ps
module ess_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last,
    output logic                 in_ready,
    input  ess_pkg::ess_status_t status,
    output ess_pkg::ess_cmd_t    cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_NORM   = 4'd1;
    localparam logic [3:0] S_LOG    = 4'd2;
    localparam logic [3:0] S_LADD   = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_DIVM   = 4'd5;
    localparam logic [3:0] S_DIVL0  = 4'd6;
    localparam logic [3:0] S_DIVL   = 4'd7;
    localparam logic [3:0] S_EXP0   = 4'd8;
    localparam logic [3:0] S_SQLD   = 4'd9;
    localparam logic [3:0] S_SQ     = 4'd10;
    localparam logic [3:0] S_SQEND  = 4'd11;
    localparam logic [3:0] S_GEO    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic       last_reg, last_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.norm_idx = cnt_reg[2:0];
        cmd.frac_idx = k_reg;
        cmd.sqrt_idx = cnt_reg[4:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take  = 1'b1;
                    last_next = last;
                    cnt_next  = '0;
                    if (status.log_needed)
                        state_next = S_NORM;
                    else if (last)
                        state_next = S_FIN;
                end
            end
            S_NORM:
            begin
                cmd.norm_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4)
                begin
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ess_pkg::LOG_FRAC_BITS - 1))
                    state_next = S_LADD;
            end
            S_LADD:
            begin
                cmd.log_add = 1'b1;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                cnt_next = '0;
                if (status.count_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_load_mean = 1'b1;
                    state_next = S_DIVM;
                end
            end
            S_DIVM:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ess_pkg::DIVD_W - 1))
                    state_next = S_DIVL0;
            end
            S_DIVL0:
            begin
                cmd.mean_save    = 1'b1;
                cmd.div_load_log = 1'b1;
                cnt_next   = '0;
                state_next = S_DIVL;
            end
            S_DIVL:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ess_pkg::DIVD_W - 1))
                    state_next = S_EXP0;
            end
            S_EXP0:
            begin
                k_next = '0;
                if (status.zero_flag)
                    state_next = S_OUT;
                else
                begin
                    cmd.l_save = 1'b1;
                    state_next = S_SQLD;
                end
            end
            S_SQLD:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ess_pkg::SQRT_STEPS - 1))
                    state_next = S_SQEND;
            end
            S_SQEND:
            begin
                cmd.sqrt_end = 1'b1;
                k_next = k_reg + 4'd1;
                state_next = (k_reg == 4'(ess_pkg::LOG_FRAC_BITS - 1)) ? S_GEO : S_SQLD;
            end
            S_GEO:
            begin
                cmd.geo_save = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end
endmodule

FILE: design/ess_datapath.sv
// Accumulators, log2 unit, shared divider, square-root unit and output register.
`timescale 1ns / 1ps
module ess_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [31:0]       sample,
    input  logic                     has_sample,
    input  ess_pkg::ess_cmd_t        cmd,
    output ess_pkg::ess_status_t     status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [10:0]              sample_count,
    output logic signed [41:0]       total,
    output logic signed [31:0]       smallest,
    output logic signed [31:0]       largest,
    output logic signed [39:0]       mean_fixed,
    output logic [38:0]              geom_fixed,
    output logic                     empty_flag,
    output logic                     zero_seen
);
    localparam logic signed [31:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAX_RESET = 32'sh8000_0000;

    logic [10:0]        count_reg, count_next;
    logic signed [41:0] sum_reg, sum_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic [31:0]        log_reg, log_next;
    logic               zf_reg, zf_next;
    logic [31:0]        m_reg, m_next;
    logic [4:0]         e_reg, e_next;
    logic [15:0]        frac_reg, frac_next;
    logic [49:0]        d_reg, d_next;
    logic [10:0]        rem_reg, rem_next;
    logic [39:0]        mean_reg, mean_next;
    logic [31:0]        l_reg, l_next;
    logic [31:0]        y_reg, y_next;
    logic [63:0]        n_reg, n_next;
    logic [63:0]        res_reg, res_next;
    logic [38:0]        geom_reg, geom_next;
    logic               ov_reg, ov_next;
    logic [10:0]        oc_reg, oc_next;
    logic signed [41:0] os_reg, os_next;
    logic signed [31:0] omin_reg, omin_next;
    logic signed [31:0] omax_reg, omax_next;
    logic [39:0]        om_reg, om_next;
    logic [38:0]        og_reg, og_next;
    logic               oe_reg, oe_next;
    logic               oz_reg, oz_next;

    logic        take_ok;
    logic [31:0] mag;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [32:0] log_sum;
    logic [41:0] sum_mag;
    logic [11:0] r_ext;
    logic        ge;
    logic [32:0] v;
    logic [63:0] bitv;
    logic [63:0] t;
    logic [63:0] g64;
    logic [49:0] q_neg;

    assign take_ok = cmd.take && has_sample && (count_reg < 11'(ess_pkg::MAX_SAMPLES));
    assign mag     = sample[31] ? 32'(-sample) : sample;
    assign sq      = 64'(m_reg) * 64'(m_reg);
    assign sq_sh   = sq[63:31];
    assign log_sum = {1'b0, log_reg} + {12'd0, e_reg, frac_reg};
    assign sum_mag = sum_reg[41] ? 42'(-sum_reg) : sum_reg;
    assign r_ext   = {rem_reg, d_reg[49]};
    assign ge      = r_ext >= {1'b0, count_reg};
    assign v       = l_reg[cmd.frac_idx] ? {y_reg, 1'b0} : {1'b0, y_reg};
    assign bitv    = 64'h4000_0000_0000_0000 >> {cmd.sqrt_idx, 1'b0};
    assign t       = res_reg + bitv;
    assign g64     = {32'd0, y_reg} << l_reg[20:16];
    assign q_neg   = 50'(-d_reg);

    assign status.log_needed = take_ok && (sample != 32'sd0);
    assign status.count_zero = (count_reg == 11'd0);
    assign status.zero_flag  = zf_reg;
    assign status.out_free   = !ov_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        log_next   = log_reg;
        zf_next    = zf_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        frac_next  = frac_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        mean_next  = mean_reg;
        l_next     = l_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        geom_next  = geom_reg;
        ov_next    = ov_reg;
        oc_next    = oc_reg;
        os_next    = os_reg;
        omin_next  = omin_reg;
        omax_next  = omax_reg;
        om_next    = om_reg;
        og_next    = og_reg;
        oe_next    = oe_reg;
        oz_next    = oz_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        if (take_ok)
        begin
            count_next = count_reg + 11'd1;
            sum_next   = sum_reg + 42'(sample);
            if (sample < min_reg)
                min_next = sample;
            if (sample > max_reg)
                max_next = sample;
            if (sample == 32'sd0)
                zf_next = 1'b1;
            m_next    = mag;
            e_next    = 5'd31;
            frac_next = '0;
        end

        if (cmd.norm_step)
        begin
            case (cmd.norm_idx)
                3'd0:
                begin
                    if (m_reg[31:16] == '0)
                    begin
                        m_next = {m_reg[15:0], 16'd0};
                        e_next = e_reg - 5'd16;
                    end
                end
                3'd1:
                begin
                    if (m_reg[31:24] == '0)
                    begin
                        m_next = {m_reg[23:0], 8'd0};
                        e_next = e_reg - 5'd8;
                    end
                end
                3'd2:
                begin
                    if (m_reg[31:28] == '0)
                    begin
                        m_next = {m_reg[27:0], 4'd0};
                        e_next = e_reg - 5'd4;
                    end
                end
                3'd3:
                begin
                    if (m_reg[31:30] == '0)
                    begin
                        m_next = {m_reg[29:0], 2'd0};
                        e_next = e_reg - 5'd2;
                    end
                end
                default:
                begin
                    if (!m_reg[31])
                    begin
                        m_next = {m_reg[30:0], 1'b0};
                        e_next = e_reg - 5'd1;
                    end
                end
            endcase
        end

        if (cmd.log_step)
        begin
            if (sq_sh[32])
            begin
                m_next    = sq_sh[32:1];
                frac_next = {frac_reg[14:0], 1'b1};
            end
            else
            begin
                m_next    = sq_sh[31:0];
                frac_next = {frac_reg[14:0], 1'b0};
            end
        end

        if (cmd.log_add)
            log_next = log_sum[32] ? 32'hFFFF_FFFF : log_sum[31:0];

        if (cmd.div_load_mean)
        begin
            d_next   = {sum_mag, 8'd0};
            rem_next = '0;
        end
        if (cmd.div_load_log)
        begin
            d_next   = {18'd0, log_reg};
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = ge ? 11'(r_ext - {1'b0, count_reg}) : r_ext[10:0];
            d_next   = {d_reg[48:0], ge};
        end
        if (cmd.mean_save)
            mean_next = sum_reg[41] ? q_neg[39:0] : d_reg[39:0];
        if (cmd.l_save)
        begin
            l_next = d_reg[31:0];
            y_next = 32'h4000_0000;
        end

        if (cmd.sqrt_load)
        begin
            n_next   = {1'b0, v, 30'd0};
            res_next = '0;
        end
        if (cmd.sqrt_step)
        begin
            if (n_reg >= t)
            begin
                n_next   = n_reg - t;
                res_next = (res_reg >> 1) + bitv;
            end
            else
                res_next = res_reg >> 1;
        end
        if (cmd.sqrt_end)
            y_next = res_reg[31:0];

        if (cmd.geo_save)
        begin
            if ((l_reg[31:21] != '0) || (g64[63:61] != '0))
                geom_next = '1;
            else
                geom_next = g64[60:22];
        end

        if (cmd.out_load)
        begin
            ov_next   = 1'b1;
            oc_next   = count_reg;
            os_next   = sum_reg;
            omin_next = min_reg;
            omax_next = max_reg;
            om_next   = (count_reg == '0) ? '0 : mean_reg;
            og_next   = ((count_reg == '0) || zf_reg) ? '0 : geom_reg;
            oe_next   = (count_reg == '0);
            oz_next   = zf_reg;
            count_next = '0;
            sum_next   = '0;
            min_next   = MIN_RESET;
            max_next   = MAX_RESET;
            log_next   = '0;
            zf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= MIN_RESET;
            max_reg   <= MAX_RESET;
            log_reg   <= '0;
            zf_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            log_reg   <= log_next;
            zf_reg    <= zf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        mean_reg <= mean_next;
        l_reg    <= l_next;
        y_reg    <= y_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        geom_reg <= geom_next;
        oc_reg   <= oc_next;
        os_reg   <= os_next;
        omin_reg <= omin_next;
        omax_reg <= omax_next;
        om_reg   <= om_next;
        og_reg   <= og_next;
        oe_reg   <= oe_next;
        oz_reg   <= oz_next;
    end

    assign out_valid    = ov_reg;
    assign sample_count = oc_reg;
    assign total        = os_reg;
    assign smallest     = omin_reg;
    assign largest      = omax_reg;
    assign mean_fixed   = om_reg;
    assign geom_fixed   = og_reg;
    assign empty_flag   = oe_reg;
    assign zero_seen    = oz_reg;
endmodule

FILE: design/event_sample_statistics.sv
// Top level of the event sample statistics block.
// One transaction at a time. A zero or discarded sample needs no log; a nonzero one runs
// 5 normalize steps, 16 squarings in the log2 unit and 1 accumulate, then back to idle.
// An event end runs the shared bit-serial divider for the mean and the log sum, then the
// square-root unit (an empty event skips both), then loads the output register when free.
// Reset (rst_n low, asynchronous) clears all accumulators and the output valid.
`timescale 1ns / 1ps
module event_sample_statistics (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    input  logic               has_sample,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [10:0]        sample_count,
    output logic signed [41:0] total,
    output logic signed [31:0] smallest,
    output logic signed [31:0] largest,
    output logic signed [39:0] mean_fixed,
    output logic [38:0]        geom_fixed,
    output logic               empty_flag,
    output logic               zero_seen
);
    ess_pkg::ess_cmd_t    cmd;
    ess_pkg::ess_status_t status;

    ess_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ess_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .has_sample   (has_sample),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .sample_count (sample_count),
        .total        (total),
        .smallest     (smallest),
        .largest      (largest),
        .mean_fixed   (mean_fixed),
        .geom_fixed   (geom_fixed),
        .empty_flag   (empty_flag),
        .zero_seen    (zero_seen)
    );
endmodule

FILE: design/ess_checker.sv
// Port-level checks on the event sample statistics block, bound to the top level.
`timescale 1ns / 1ps
module ess_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [10:0]        sample_count,
    input logic signed [41:0] total,
    input logic signed [31:0] smallest,
    input logic signed [31:0] largest,
    input logic [38:0]        geom_fixed,
    input logic               empty_flag,
    input logic               zero_seen
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_flag |-> sample_count == 11'd0 && total == 42'sd0 && !zero_seen)
        else $error("empty event with nonzero statistics");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_seen |-> geom_fixed == 39'd0)
        else $error("zero sample but geometric mean nonzero");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_flag |-> smallest <= largest && sample_count != 11'd0)
        else $error("min above max in nonempty event");
endmodule

bind event_sample_statistics ess_checker u_ess_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_count (sample_count),
    .total        (total),
    .smallest     (smallest),
    .largest      (largest),
    .geom_fixed   (geom_fixed),
    .empty_flag   (empty_flag),
    .zero_seen    (zero_seen)
);

FILE: sim/event_sample_statistics_checker.sv
// Checker for event_sample_statistics: predicts each event result and compares it.
`timescale 1ns / 1ps
module event_sample_statistics_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] sample,
    input  logic               has_sample,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [10:0]        sample_count,
    input  logic signed [41:0] total,
    input  logic signed [31:0] smallest,
    input  logic signed [31:0] largest,
    input  logic signed [39:0] mean_fixed,
    input  logic [38:0]        geom_fixed,
    input  logic               empty_flag,
    input  logic               zero_seen,
    output int                 fail_count,
    output int                 pending
);
    typedef struct packed {
        logic [10:0]        cnt;
        logic signed [41:0] sum;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [39:0] mean;
        logic [38:0]        geom;
        logic               empty;
        logic               zero;
    } event_stats_t;

    event_stats_t stats_q[$];

    logic [10:0]        cnt_acc;
    logic signed [41:0] sum_acc;
    logic signed [31:0] lo_acc;
    logic signed [31:0] hi_acc;
    logic [32:0]        logsum_acc;
    logic               zero_acc;

    assign pending = stats_q.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] log2_mag(input logic [31:0] mag);
        int          e;
        logic [63:0] m;
        logic [31:0] frac;
        e = 31;
        while (!mag[e]) e--;
        m = 64'(mag) << (31 - e);
        frac = 0;
        for (int k = 0; k < ess_pkg::LOG_FRAC_BITS; k++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (32'(e) << ess_pkg::LOG_FRAC_BITS) | frac;
    endfunction

    function automatic logic [38:0] geo_from_log(input logic [31:0] l);
        logic [31:0] ip;
        logic [63:0] y;
        logic [63:0] v;
        logic [63:0] g;
        ip = l >> ess_pkg::LOG_FRAC_BITS;
        y = 64'd1 << 30;
        for (int k = 0; k < ess_pkg::LOG_FRAC_BITS; k++)
        begin
            v = l[k] ? (y << 1) : y;
            y = int_sqrt(v << 30);
        end
        if (ip >= 32) return '1;
        g = (y << ip) >> 22;
        return (g > 64'h7F_FFFF_FFFF) ? 39'h7F_FFFF_FFFF : g[38:0];
    endfunction

    task automatic clear_acc();
        cnt_acc = 0;
        sum_acc = 0;
        lo_acc = 32'sh7FFF_FFFF;
        hi_acc = 32'sh8000_0000;
        logsum_acc = 0;
        zero_acc = 0;
    endtask

    task automatic absorb_sample(input logic signed [31:0] s, input logic h, input logic l);
        event_stats_t e;
        logic [63:0]  mag;
        logic [63:0]  q;
        if (h && cnt_acc < ess_pkg::MAX_SAMPLES)
        begin
            cnt_acc++;
            sum_acc = sum_acc + s;
            if (s < lo_acc) lo_acc = s;
            if (s > hi_acc) hi_acc = s;
            if (s == 0)
                zero_acc = 1;
            else
            begin
                logsum_acc = logsum_acc + log2_mag(s < 0 ? 32'(-64'(s)) : 32'(s));
                if (logsum_acc[32]) logsum_acc = 33'h0_FFFF_FFFF;
            end
        end
        if (!l) return;
        e.cnt = cnt_acc;
        e.sum = sum_acc;
        e.lo = lo_acc;
        e.hi = hi_acc;
        e.mean = 0;
        e.geom = 0;
        e.empty = (cnt_acc == 0);
        e.zero = zero_acc;
        if (cnt_acc != 0)
        begin
            mag = sum_acc < 0 ? 64'(-64'(sum_acc)) : 64'(sum_acc);
            q = (mag << 8) / cnt_acc;
            e.mean = sum_acc < 0 ? 40'(-q) : 40'(q);
            if (!zero_acc) e.geom = geo_from_log(32'(logsum_acc / cnt_acc));
        end
        stats_q.push_back(e);
        clear_acc();
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        clear_acc();
    end

    always @(posedge clk)
    begin
        event_stats_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    e = stats_q.pop_front();
                    if (sample_count !== e.cnt) report("sample_count", sample_count, e.cnt);
                    if (total !== e.sum) report("total", total, e.sum);
                    if (smallest !== e.lo) report("smallest", smallest, e.lo);
                    if (largest !== e.hi) report("largest", largest, e.hi);
                    if (mean_fixed !== e.mean) report("mean_fixed", mean_fixed, e.mean);
                    if (geom_fixed !== e.geom) report("geom_fixed", geom_fixed, e.geom);
                    if (empty_flag !== e.empty) report("empty_flag", empty_flag, e.empty);
                    if (zero_seen !== e.zero) report("zero_seen", zero_seen, e.zero);
                end
            end
            if (in_valid && in_ready)
                absorb_sample(sample, has_sample, last);
        end
    end
endmodule

FILE: sim/event_sample_statistics_test.sv
// Testbench top for event_sample_statistics: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module event_sample_statistics_test;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] sample = 0;
    logic               has_sample = 0;
    logic               last = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [10:0]        sample_count;
    logic signed [41:0] total;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic signed [39:0] mean_fixed;
    logic [38:0]        geom_fixed;
    logic               empty_flag;
    logic               zero_seen;
    int                 fail_count;
    int                 pending;
    bit                 calm = 0;
    longint             cycles = 0;

    always #10 clk = ~clk;

    event_sample_statistics dut (.*);

    event_sample_statistics_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[event_sample_statistics] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);

    task automatic send(input logic signed [31:0] s, input logic h, input logic l);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        sample <= s;
        has_sample <= h;
        last <= l;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(7))
            0: return 0;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return $urandom_range(1, 16);
            4: return -$signed(32'($urandom_range(1, 300)));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int items;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(0, 0, 1);
        send(32'sh7FFF_FFFF, 1, 0);
        send(32'sh8000_0000, 1, 1);
        send(1, 1, 0);
        send(0, 0, 0);
        send(-1, 1, 1);
        send(5, 1, 0);
        send(0, 1, 0);
        send(-7, 1, 1);
        send(32'sh7FFF_FFFF, 1, 0);
        send(32'sh7FFF_FFFF, 1, 0);
        send(3, 0, 1);
        send(-3, 1, 1);
        send(32'h5555_5555, 1, 0);
        send(32'shAAAA_AAAA, 1, 1);
        send(0, 1, 1);
        // overflow of the sample count: 1030 samples, extras ignored
        calm = 1;
        for (int i = 0; i < 1030; i++)
            send(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 1, i == 1029);
        calm = 0;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (700) @(posedge clk);
        items = 0;
        while (items < 250)
        begin
            calm = (items > 100 && items < 160);
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                send(rand_value(), $urandom_range(9) != 0, 0);
                items++;
            end
            send(rand_value(), $urandom_range(3) != 0, 1);
            items++;
            if (items > 40 && items < 70)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
        end
        calm = 0;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (800) @(posedge clk);
        if (fail_count == 0)
            $display("[event_sample_statistics] OK");
        else
            $display("[event_sample_statistics] ERROR");
        $finish;
    end
endmodule
